// ----- hdl/capsule_support_point_top_defines.svh -----
// Assertion helpers for the capsule support point block.
`ifndef CAPSULE_SUPPORT_POINT_TOP_DEFINES_SVH
`define CAPSULE_SUPPORT_POINT_TOP_DEFINES_SVH

// same-cycle implication
`define CSP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/capsp_pkg.sv -----
package capsp_pkg;

    typedef struct packed {
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } t_dir_word;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               saturated;
    } t_point_word;

    typedef enum logic [2:0] {
        REG_RADIUS,
        REG_CYL_HEIGHT,
        REG_AXIS_X,
        REG_AXIS_Y,
        REG_AXIS_Z,
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_CENTER_Z
    } t_reg_idx;

    localparam int          ADDR_W      = 5;
    localparam logic [31:0] AXIS_X_RST  = 32'h4000_0000;
    localparam logic [31:0] UNIT_ONE    = 32'h4000_0000;
    localparam logic [31:0] SAT_POS     = 32'h7fff_ffff;
    localparam logic [31:0] SAT_NEG     = 32'h8000_0000;

endpackage

// ----- hdl/capsule_support_point_top.sv -----
// Capsule support point: one direction word in, one point word out per cycle.
// The path from accept to output valid runs through the front registers, the square root
// stages, the restoring divide stages and the back-end registers.
// Throughput: one word per cycle while the output is not stalled.
// Reset: synchronous, active low; clears valid bits, the skid and the registers
// (axis resets to +X); pipeline payload is not reset.
`include "capsule_support_point_top_defines.svh"

module capsule_support_point_top #(
    parameter int SQRT_ITERATIONS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // direction channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  capsp_pkg::t_dir_word        i_in_word,
    // support point channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output capsp_pkg::t_point_word      o_out_word,
    // register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [capsp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import capsp_pkg::*;

    localparam int SI = SQRT_ITERATIONS;
    localparam int ND = SI + 30;          // divide steps: 32 dividend bits + SI-2 zero bits
    localparam logic [32:0] Q_CAP = 33'h0_8000_0000;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [30:0]        r_radius;
    logic [30:0]        r_height;
    logic signed [31:0] r_axis   [3];
    logic signed [31:0] r_center [3];
    logic signed [32:0] r_half   [3];   // axis*height/2^31, floored

    t_reg_idx cfg_idx;
    assign cfg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius    <= '0;
            r_height    <= '0;
            r_axis[0]   <= AXIS_X_RST;
            r_axis[1]   <= '0;
            r_axis[2]   <= '0;
            r_center[0] <= '0;
            r_center[1] <= '0;
            r_center[2] <= '0;
        end else if (psel && penable && pwrite) begin
            case (cfg_idx)
                REG_RADIUS:     r_radius    <= pwdata[30:0];
                REG_CYL_HEIGHT: r_height    <= pwdata[30:0];
                REG_AXIS_X:     r_axis[0]   <= pwdata;
                REG_AXIS_Y:     r_axis[1]   <= pwdata;
                REG_AXIS_Z:     r_axis[2]   <= pwdata;
                REG_CENTER_X:   r_center[0] <= pwdata;
                REG_CENTER_Y:   r_center[1] <= pwdata;
                REG_CENTER_Z:   r_center[2] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_RADIUS:     prdata = {1'b0, r_radius};
            REG_CYL_HEIGHT: prdata = {1'b0, r_height};
            REG_AXIS_X:     prdata = r_axis[0];
            REG_AXIS_Y:     prdata = r_axis[1];
            REG_AXIS_Z:     prdata = r_axis[2];
            REG_CENTER_X:   prdata = r_center[0];
            REG_CENTER_Y:   prdata = r_center[1];
            REG_CENTER_Z:   prdata = r_center[2];
            default:        prdata = '0;
        endcase
    end

    // Half axis offset only changes on a register write; the user is to write with the pipeline
    // empty, which the block does not enforce, so it is kept as a free-running registered product.
    logic signed [63:0] n_half_prod [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_half_prod[k] = r_axis[k] * $signed({1'b0, r_height});
        end
    end
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_half[k] <= n_half_prod[k][63:31];
        end
    end

    // ------------------------------------------------------------------
    // Flow control: the whole pipe moves unless the skid holds a word
    // ------------------------------------------------------------------
    logic        r_skid_full;
    t_point_word r_skid;
    logic        r_last_v;
    t_point_word r_last;
    logic        en;

    assign en         = !r_skid_full;
    assign o_in_stall = r_skid_full;

    // ------------------------------------------------------------------
    // Front: input register, magnitudes + shift count, shift, squares
    // ------------------------------------------------------------------
    logic               r0_v, r1_v, r2_v, r3_v;
    logic signed [31:0] r0_d [3];
    logic [31:0]        r1_m [3];
    logic [4:0]         r1_sh;
    logic               r1_zero;
    logic [2:0]         r1_neg;
    logic [31:0]        r2_m [3];
    logic               r2_zero;
    logic [2:0]         r2_neg;
    logic [63:0]        r3_sq [3];
    logic [31:0]        r3_m [3];
    logic               r3_zero;
    logic [2:0]         r3_neg;

    logic [31:0] n1_m [3];
    logic [31:0] n1_or;
    logic [4:0]  n1_top;
    logic [4:0]  n1_sh;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n1_m[k] = r0_d[k][31] ? 32'(-r0_d[k]) : 32'(r0_d[k]);
        end
        n1_or  = n1_m[0] | n1_m[1] | n1_m[2];
        n1_top = '0;
        for (int j = 0; j < 32; j++) begin
            if (n1_or[j]) n1_top = 5'(j);
        end
        // bring the largest magnitude up to at least 2^30
        n1_sh = (n1_top >= 5'd30) ? 5'd0 : 5'd30 - n1_top;
    end

    // ------------------------------------------------------------------
    // Square root: one restoring step per stage, index 0 holds the sum
    // ------------------------------------------------------------------
    logic [SI:0]   r_sq_v;
    logic [SI+1:0] r_sq_rem  [SI+1];
    logic [SI-1:0] r_sq_root [SI+1];
    logic [63:0]   r_sq_s    [SI+1];
    logic [31:0]   r_sq_m    [SI+1][3];
    logic          r_sq_zero [SI+1];
    logic [2:0]    r_sq_neg  [SI+1];

    logic [SI+1:0] n_sq_rem  [SI];
    logic [SI-1:0] n_sq_root [SI];
    logic [SI+1:0] sq_t      [SI];
    logic [SI+1:0] sq_trial  [SI];

    always_comb begin
        for (int j = 0; j < SI; j++) begin
            sq_t[j]     = {r_sq_rem[j][SI-1:0], r_sq_s[j][63:62]};
            sq_trial[j] = {r_sq_root[j], 2'b01};
            if (sq_t[j] >= sq_trial[j]) begin
                n_sq_rem[j]  = sq_t[j] - sq_trial[j];
                n_sq_root[j] = {r_sq_root[j][SI-2:0], 1'b1};
            end else begin
                n_sq_rem[j]  = sq_t[j];
                n_sq_root[j] = {r_sq_root[j][SI-2:0], 1'b0};
            end
        end
    end

    // ------------------------------------------------------------------
    // Divide: three lanes of restoring division by the root
    // ------------------------------------------------------------------
    logic [ND:0]   r_dv_v;
    logic [SI:0]   r_dv_rem  [ND+1][3];
    logic [31:0]   r_dv_q    [ND+1][3];
    logic [31:0]   r_dv_m    [ND+1][3];
    logic [SI-1:0] r_dv_root [ND+1];
    logic          r_dv_zero [ND+1];
    logic [2:0]    r_dv_neg  [ND+1];

    logic [SI:0]   n_dv_rem [ND][3];
    logic [31:0]   n_dv_q   [ND][3];
    logic [SI:0]   dv_t     [ND][3];
    logic [32:0]   dv_qt    [ND][3];

    always_comb begin
        for (int j = 0; j < ND; j++) begin
            for (int k = 0; k < 3; k++) begin
                dv_t[j][k] = {r_dv_rem[j][k][SI-1:0], r_dv_m[j][k][31]};
                if (dv_t[j][k] >= {1'b0, r_dv_root[j]}) begin
                    n_dv_rem[j][k] = dv_t[j][k] - {1'b0, r_dv_root[j]};
                    dv_qt[j][k]    = {r_dv_q[j][k], 1'b1};
                end else begin
                    n_dv_rem[j][k] = dv_t[j][k];
                    dv_qt[j][k]    = {r_dv_q[j][k], 1'b0};
                end
                n_dv_q[j][k] = (dv_qt[j][k] > Q_CAP) ? 32'(Q_CAP) : dv_qt[j][k][31:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Back end: unit vector, radial product, dot test, final sum + clip
    // ------------------------------------------------------------------
    logic               ru_v, rp_v, rd_v, rt_v;
    logic signed [31:0] ru_u  [3];
    logic signed [63:0] rp_pr [3];
    logic signed [32:0] rd_r  [3];
    logic signed [65:0] rd_dot[3];
    logic signed [32:0] rt_r  [3];
    logic               rt_pos;

    logic [31:0]        n_qc  [3];
    logic signed [31:0] n_u   [3];
    logic signed [66:0] n_tot;
    logic signed [34:0] n_p   [3];
    logic signed [34:0] n_off [3];
    t_point_word        n_out;
    logic [31:0]        n_pc  [3];
    logic               n_sat;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_qc[k] = (r_dv_q[ND][k] > UNIT_ONE) ? UNIT_ONE : r_dv_q[ND][k];
            if (r_dv_zero[ND]) begin
                n_u[k] = (k == 0) ? UNIT_ONE : '0;   // zero direction maps to +X
            end else begin
                n_u[k] = r_dv_neg[ND][k] ? -$signed(n_qc[k]) : $signed(n_qc[k]);
            end
        end
        n_tot = 67'(rd_dot[0]) + 67'(rd_dot[1]) + 67'(rd_dot[2]);
        n_sat = 1'b0;
        for (int k = 0; k < 3; k++) begin
            // +offset end only when strictly farther from the centre
            n_off[k] = rt_pos ? 35'(r_half[k]) : -35'(r_half[k]);
            n_p[k]   = 35'(r_center[k]) + n_off[k] + 35'(rt_r[k]);
            if (n_p[k] > 35'sd2147483647) begin
                n_pc[k] = SAT_POS;
                n_sat   = 1'b1;
            end else if (n_p[k] < -35'sd2147483648) begin
                n_pc[k] = SAT_NEG;
                n_sat   = 1'b1;
            end else begin
                n_pc[k] = n_p[k][31:0];
            end
        end
        n_out.point_x   = n_pc[0];
        n_out.point_y   = n_pc[1];
        n_out.point_z   = n_pc[2];
        n_out.saturated = n_sat;
    end

    // ------------------------------------------------------------------
    // Valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v     <= 1'b0;
            r1_v     <= 1'b0;
            r2_v     <= 1'b0;
            r3_v     <= 1'b0;
            r_sq_v   <= '0;
            r_dv_v   <= '0;
            ru_v     <= 1'b0;
            rp_v     <= 1'b0;
            rd_v     <= 1'b0;
            rt_v     <= 1'b0;
            r_last_v <= 1'b0;
        end else if (en) begin
            r0_v     <= i_in_valid;
            r1_v     <= r0_v;
            r2_v     <= r1_v;
            r3_v     <= r2_v;
            r_sq_v   <= {r_sq_v[SI-1:0], r3_v};
            r_dv_v   <= {r_dv_v[ND-1:0], r_sq_v[SI]};
            ru_v     <= r_dv_v[ND];
            rp_v     <= ru_v;
            rd_v     <= rp_v;
            rt_v     <= rd_v;
            r_last_v <= rt_v;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_d[0] <= i_in_word.dir_x;
            r0_d[1] <= i_in_word.dir_y;
            r0_d[2] <= i_in_word.dir_z;

            r1_sh   <= n1_sh;
            r1_zero <= (n1_or == '0);
            r1_neg  <= {r0_d[2][31], r0_d[1][31], r0_d[0][31]};
            r2_zero <= r1_zero;
            r2_neg  <= r1_neg;
            r3_zero <= r2_zero;
            r3_neg  <= r2_neg;
            for (int k = 0; k < 3; k++) begin
                r1_m[k]  <= n1_m[k];
                r2_m[k]  <= r1_m[k] << r1_sh;
                r3_sq[k] <= r2_m[k] * r2_m[k];
                r3_m[k]  <= r2_m[k];
            end

            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_s[0]    <= r3_sq[0] + r3_sq[1] + r3_sq[2];
            r_sq_zero[0] <= r3_zero;
            r_sq_neg[0]  <= r3_neg;
            for (int k = 0; k < 3; k++) r_sq_m[0][k] <= r3_m[k];
            for (int j = 0; j < SI; j++) begin
                r_sq_rem[j+1]  <= n_sq_rem[j];
                r_sq_root[j+1] <= n_sq_root[j];
                r_sq_s[j+1]    <= {r_sq_s[j][61:0], 2'b00};
                r_sq_zero[j+1] <= r_sq_zero[j];
                r_sq_neg[j+1]  <= r_sq_neg[j];
                for (int k = 0; k < 3; k++) r_sq_m[j+1][k] <= r_sq_m[j][k];
            end

            r_dv_root[0] <= r_sq_root[SI];
            r_dv_zero[0] <= r_sq_zero[SI];
            r_dv_neg[0]  <= r_sq_neg[SI];
            for (int k = 0; k < 3; k++) begin
                r_dv_rem[0][k] <= '0;
                r_dv_q[0][k]   <= '0;
                r_dv_m[0][k]   <= r_sq_m[SI][k];
            end
            for (int j = 0; j < ND; j++) begin
                r_dv_root[j+1] <= r_dv_root[j];
                r_dv_zero[j+1] <= r_dv_zero[j];
                r_dv_neg[j+1]  <= r_dv_neg[j];
                for (int k = 0; k < 3; k++) begin
                    r_dv_rem[j+1][k] <= n_dv_rem[j][k];
                    r_dv_q[j+1][k]   <= n_dv_q[j][k];
                    r_dv_m[j+1][k]   <= {r_dv_m[j][k][30:0], 1'b0};
                end
            end

            for (int k = 0; k < 3; k++) begin
                ru_u[k]   <= n_u[k];
                rp_pr[k]  <= ru_u[k] * $signed({1'b0, r_radius});
                rd_r[k]   <= rp_pr[k][62:30];
                rd_dot[k] <= r_half[k] * $signed(rp_pr[k][62:30]);
                rt_r[k]   <= rd_r[k];
            end
            rt_pos <= (n_tot > 67'sd0);
            r_last <= n_out;
        end
    end

    // ------------------------------------------------------------------
    // Output skid: catches the last word when the sink stalls
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_full <= 1'b0;
        end else if (en) begin
            if (r_last_v && i_out_stall) r_skid_full <= 1'b1;
        end else if (!i_out_stall) begin
            r_skid_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_last_v && i_out_stall) r_skid <= r_last;
    end

    assign o_out_valid = r_skid_full || r_last_v;
    assign o_out_word  = r_skid_full ? r_skid : r_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `CSP_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_in_valid && !o_in_stall, r0_v,
        "accepted word did not enter the pipe")
    `CSP_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_skid_full && !i_out_stall, !r_skid_full,
        "skid not released after its word was taken")
    `CSP_ASSERT_NOW(a_sat_clipped, i_clk, i_rst_n, o_out_valid && o_out_word.saturated,
        (o_out_word.point_x == SAT_POS) || (o_out_word.point_x == SAT_NEG) ||
        (o_out_word.point_y == SAT_POS) || (o_out_word.point_y == SAT_NEG) ||
        (o_out_word.point_z == SAT_POS) || (o_out_word.point_z == SAT_NEG),
        "saturated flag without a clipped coordinate")

endmodule
